### rtl/ump_group_remap_forwarder_assert.svh
// Assertion macros for the UMP group-remap forwarder.
// Used by the top level; needs nothing else.
`ifndef UMP_GROUP_REMAP_FORWARDER_ASSERT_SVH
`define UMP_GROUP_REMAP_FORWARDER_ASSERT_SVH

// Implication within the same cycle, gated off during reset.
`define UGR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the following cycle, gated off during reset.
`define UGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ugr_pkg.sv
// Shared types, constants and the UMP length table of the group-remap forwarder.
// No dependencies.
package ugr_pkg;

    localparam int WORDS_MAX  = 4;
    localparam int FIFO_DEPTH = 4;

    localparam logic [31:0] GROUP_CLEAR_MASK = 32'hF0FF_FFFF;
    localparam logic [3:0]  NIBBLE_MASK      = 4'hF;
    localparam logic [3:0]  MT_UTILITY       = 4'h0;
    localparam logic [3:0]  MT_RESERVED      = 4'hE;
    localparam logic [3:0]  MT_STREAM        = 4'hF;
    localparam int          MT_SHIFT         = 28;
    localparam int          GROUP_SHIFT      = 24;

    // One complete packet waiting for the back end
    typedef struct packed {
        logic [WORDS_MAX-1:0][31:0] words;
        logic [1:0]                 last_idx;
    } pkt_t;

    // Packet length in words for a message type
    function automatic logic [2:0] mt_words(input logic [3:0] mt);
        logic [2:0] len;
        case (mt) inside
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: len = 3'd1;
            4'h3, 4'h4, 4'h8, 4'h9, 4'hA: len = 3'd2;
            4'hB, 4'hC:                   len = 3'd3;
            default:                      len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

### rtl/ump_group_remap_forwarder.sv
// UMP group-remap forwarder: one word accepted per cycle while the queue has room,
// one word out per cycle while m_tready is high. A packet's last input word writes
// it into the packet queue (4 packets), which sets how far input runs ahead; the
// back end then loads its words back to back into the registered output.
// rst_n (asynchronous, active low) closes any open packet, empties the queue,
// and clears forward_enable.
`include "ump_group_remap_forwarder_assert.svh"

module ump_group_remap_forwarder
    import ugr_pkg::*;
#(
    parameter int NUM_SLOTS       = 4,
    parameter int GROUPS_PER_SLOT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // forward_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [31:0] ump_word
    input  logic [3:0]  s_tuser,       // [3:0] slot_index
    input  logic        s_tlast,       // buffer_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] out_word
    output logic        m_tlast        // packet_end
);

    logic forward_enable_reg;
    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    pkt_t push_pkt;
    pkt_t head_pkt;

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            forward_enable_reg <= 1'b0;
        else if (cfg_we)
            forward_enable_reg <= cfg_wdata;
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    ugr_front #(
        .NUM_SLOTS       (NUM_SLOTS),
        .GROUPS_PER_SLOT (GROUPS_PER_SLOT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .slot_index     (s_tuser),
        .ump_word       (s_tdata),
        .buffer_last    (s_tlast),
        .forward_enable (forward_enable_reg),
        .push           (push),
        .push_pkt       (push_pkt)
    );

    ugr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .head_pkt (head_pkt),
        .empty    (empty),
        .full     (full)
    );

    ugr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_pkt   (head_pkt),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (m_tdata),
        .packet_end (m_tlast)
    );

    // Queue and forwarding checks
    `UGR_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !full, "packet pushed into full queue")
    `UGR_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !empty, "packet popped from empty queue")
    `UGR_ASSERT_SAME(a_no_push_disabled, clk, rst_n, push, forward_enable_reg && accept,
                     "packet forwarded while disabled or without input")
    `UGR_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !empty, "pushed packet lost")

endmodule

### rtl/ugr_front.sv
// Front end: assembles UMP words into packets, rewrites the group, filters.
// Depends on ugr_pkg.
module ugr_front
    import ugr_pkg::*;
#(
    parameter int NUM_SLOTS       = 4,
    parameter int GROUPS_PER_SLOT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [3:0]  slot_index,
    input  logic [31:0] ump_word,
    input  logic        buffer_last,
    input  logic        forward_enable,
    output logic        push,
    output pkt_t        push_pkt
);

    logic [31:0] held_reg [WORDS_MAX];
    logic [2:0]  expected_reg, expected_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        discard_reg, discard_next;

    logic [3:0]  mt;
    logic [3:0]  src_group;
    logic [3:0]  grp_mod;
    logic [8:0]  group_sum;
    logic [3:0]  dst_group;
    logic        first;
    logic        first_discard;
    logic [2:0]  eff_expected;
    logic [2:0]  eff_cnt;
    logic        eff_discard;
    logic [2:0]  new_cnt;
    logic        complete;
    logic [31:0] cur_word;

    // Classify the word and compute the remapped group
    always_comb
    begin
        mt        = ump_word[MT_SHIFT +: 4];
        src_group = ump_word[GROUP_SHIFT +: 4];
        grp_mod   = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (src_group == 4'(i))
                grp_mod = 4'(i % GROUPS_PER_SLOT);
        end
        group_sum = 9'(slot_index) * 9'(GROUPS_PER_SLOT) + 9'(grp_mod);
        dst_group = group_sum[3:0] & NIBBLE_MASK;

        first         = (expected_reg == '0);
        first_discard = (5'(slot_index) >= 5'(NUM_SLOTS)) || (mt == MT_UTILITY) ||
                        (mt == MT_RESERVED) || (mt == MT_STREAM);
        eff_expected  = first ? mt_words(mt) : expected_reg;
        eff_cnt       = first ? 3'd0 : cnt_reg;
        eff_discard   = first ? first_discard : discard_reg;
        cur_word      = first ? ((ump_word & GROUP_CLEAR_MASK) |
                                 ({28'b0, dst_group} << GROUP_SHIFT)) : ump_word;
        new_cnt       = eff_cnt + 3'd1;
        complete      = (new_cnt >= eff_expected);
    end

    // Build the finished packet and decide whether it goes out
    always_comb
    begin
        for (int k = 0; k < WORDS_MAX; k++)
            push_pkt.words[k] = (2'(k) == eff_cnt[1:0]) ? cur_word : held_reg[k];
        push_pkt.last_idx = eff_cnt[1:0];
        push = accept && complete && !eff_discard && forward_enable;
    end

    // Advance the packet tracking state
    always_comb
    begin
        expected_next = expected_reg;
        cnt_next      = cnt_reg;
        discard_next  = discard_reg;
        if (accept)
        begin
            if (complete || buffer_last)
            begin
                expected_next = '0;
                cnt_next      = '0;
                discard_next  = 1'b0;
            end
            else
            begin
                expected_next = eff_expected;
                cnt_next      = new_cnt;
                discard_next  = eff_discard;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            cnt_reg      <= '0;
            discard_reg  <= 1'b0;
        end
        else
        begin
            expected_reg <= expected_next;
            cnt_reg      <= cnt_next;
            discard_reg  <= discard_next;
        end
    end

    // Hold the word in its slot of the open packet
    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg[eff_cnt[1:0]] <= cur_word;
    end

endmodule

### rtl/ugr_fifo.sv
// Short packet queue between the front and back ends.
// Depends on ugr_pkg.
module ugr_fifo
    import ugr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pkt_t push_pkt,
    input  logic pop,
    output pkt_t head_pkt,
    output logic empty,
    output logic full
);

    localparam int PtrW = $clog2(FIFO_DEPTH);

    pkt_t            mem_reg [FIFO_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (PtrW+1)'(FIFO_DEPTH));
    assign head_pkt = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (PtrW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PtrW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed packet
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_pkt;
    end

endmodule

### rtl/ugr_back.sv
// Back end: serializes queued packets into words on a registered output.
// Depends on ugr_pkg.
module ugr_back
    import ugr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pkt_t        head_pkt,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic        packet_end
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [31:0] word_reg;
    logic        end_reg;
    logic        load;
    logic        at_last;

    assign out_valid  = valid_reg;
    assign out_word   = word_reg;
    assign packet_end = end_reg;

    // Load the next word when the output register frees up
    always_comb
    begin
        load     = !empty && (!valid_reg || out_ready);
        at_last  = (idx_reg == head_pkt.last_idx);
        pop      = load && at_last;
        idx_next = idx_reg;
        if (load)
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= head_pkt.words[idx_reg];
            end_reg  <= at_last;
        end
    end

endmodule
